>>> hdl/lssr_pkg.sv
// Shared types and constants for the line-scan sensor readout block.
// No dependencies; used by lssr_scale, lssr_step and line_scan_sensor_readout.
package lssr_pkg;

    localparam int PIXELS_PER_LINE = 129;
    localparam int PIX_POS_W       = $clog2(PIXELS_PER_LINE + 2);

    localparam int TICK_W   = 16;
    localparam int FRAME_W  = 16;
    localparam int SAMPLE_W = 12;
    localparam int PIXVAL_W = 8;
    localparam int PIXIDX_W = 8;

    localparam logic [TICK_W-1:0] EXPOSURE_RESET = 16'd501;

    // Input kinds (carried in s_tuser)
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Beat widths on the stream ports
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [TICK_W-1:0]    tick_count;
        logic                 clock_high;
        logic                 start_high;
        logic [PIX_POS_W-1:0] pixel_position;
        logic [FRAME_W-1:0]   frame_count;
    } lssr_state_t;

    typedef struct packed {
        logic                si_level;
        logic                clk_level;
        logic                pixel_valid;
        logic [PIXIDX_W-1:0] pixel_index;
        logic [PIXVAL_W-1:0] pixel_value;
        logic                frame_done;
        logic [FRAME_W-1:0]  frame_number;
    } lssr_result_t;

endpackage

>>> hdl/lssr_scale.sv
// Sample scaler: floor(sample*255/4000), saturated at 255.
// Depends on lssr_pkg. Pure combinational, constant multiplies only.
module lssr_scale (
    input  logic [lssr_pkg::SAMPLE_W-1:0] sample,
    output logic [lssr_pkg::PIXVAL_W-1:0] value
);

    // 255/4000 = 51/800 = (51/32)/25; 1/25 ~ 5243 / 2^17, exact below 43690
    logic [17:0] prod51;
    logic [12:0] div32;
    logic [25:0] prod_recip;
    logic [8:0]  quot;

    always_comb begin
        prod51     = 18'({6'd0, sample} * 18'd51);
        div32      = prod51[17:5];
        prod_recip = 26'({13'd0, div32} * 26'd5243);
        quot       = prod_recip[25:17];
        if (quot[8]) begin
            value = '1;
        end else begin
            value = quot[7:0];
        end
    end

endmodule

>>> hdl/lssr_step.sv
// Next-state and result logic for one beat of the readout sequencer.
// Depends on lssr_pkg and lssr_scale.
module lssr_step (
    input  lssr_pkg::lssr_state_t         cur,
    input  logic                          cmd,
    input  logic [lssr_pkg::SAMPLE_W-1:0] sample,
    input  logic [lssr_pkg::TICK_W-1:0]   exposure_count,
    output lssr_pkg::lssr_state_t         nxt,
    output lssr_pkg::lssr_result_t        res
);

    logic [lssr_pkg::PIXVAL_W-1:0] scaled;
    logic [lssr_pkg::TICK_W:0]     tick_inc;

    lssr_scale u_scale (
        .sample (sample),
        .value  (scaled)
    );

    always_comb begin
        nxt      = cur;
        res      = '0;
        tick_inc = {1'b0, cur.tick_count} + 1'b1;

        if (cmd == lssr_pkg::CMD_RESTART) begin
            nxt = '0;
        end else if (cur.tick_count == '0) begin
            nxt.start_high = 1'b1;
            nxt.clock_high = 1'b1;
            nxt.tick_count = lssr_pkg::TICK_W'(1);
        end else begin
            if (cur.clock_high) begin
                // falling clock edge
                nxt.start_high = 1'b0;
                nxt.clock_high = 1'b0;
                if (cur.pixel_position < lssr_pkg::PIX_POS_W'(lssr_pkg::PIXELS_PER_LINE)) begin
                    res.pixel_valid    = 1'b1;
                    res.pixel_index    = lssr_pkg::PIXIDX_W'(cur.pixel_position);
                    res.pixel_value    = scaled;
                    nxt.pixel_position = cur.pixel_position + 1'b1;
                end else if (cur.pixel_position ==
                             lssr_pkg::PIX_POS_W'(lssr_pkg::PIXELS_PER_LINE)) begin
                    res.frame_done     = 1'b1;
                    res.frame_number   = cur.frame_count;
                    nxt.frame_count    = cur.frame_count + 1'b1;
                    nxt.pixel_position = cur.pixel_position + 1'b1;
                end
            end else begin
                nxt.clock_high = 1'b1;
            end
            if (tick_inc > {1'b0, exposure_count}) begin
                nxt.tick_count     = '0;
                nxt.pixel_position = '0;
            end else begin
                nxt.tick_count = tick_inc[lssr_pkg::TICK_W-1:0];
            end
        end

        res.si_level  = nxt.start_high;
        res.clk_level = nxt.clock_high;
    end

endmodule

>>> hdl/line_scan_sensor_readout.sv
// Top level of the line-scan sensor readout sequencer.
// Depends on lssr_pkg and lssr_step (which uses lssr_scale).

// Every input beat is one timer tick (s_tuser = 0) or a restart (s_tuser = 1)
// and yields exactly one result beat with the SI and clock pin levels, an
// optional pixel (index and 8-bit value) and an optional frame-done mark.
// Throughput is one beat per clock while m_tready stays high: a beat lands in
// the input register when accepted, and the sequencer state and the result
// register are updated from it once the result register is free or draining.
// The input register can still take a beat while a result waits, and
// the two stages stall together only when both hold data. The exposure
// count register (reset 501) is written through cfg_wr_en/cfg_wr_data and
// should only be changed while no beat is in flight.
module line_scan_sensor_readout (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [lssr_pkg::TICK_W-1:0]      cfg_wr_data,   // exposure_count

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lssr_pkg::S_TDATA_W-1:0]   s_tdata,       // [11:0] adc_sample
    input  logic                             s_tuser,       // [0] cmd

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] si_level, [1] clk_level, [9:2] pixel_index, [17:10] pixel_value,
    // [33:18] frame_number, [39:34] zero
    output logic [lssr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [lssr_pkg::M_TUSER_W-1:0]   m_tuser        // [0] pixel_valid, [1] frame_done
);

    // input register
    logic                          in_vld_reg;
    logic                          in_cmd_reg;
    logic [lssr_pkg::SAMPLE_W-1:0] in_sample_reg;

    // sequencer state and exposure setting
    lssr_pkg::lssr_state_t         state_reg;
    lssr_pkg::lssr_state_t         state_next;
    logic [lssr_pkg::TICK_W-1:0]   exposure_reg;

    // result register
    logic                          res_vld_reg;
    lssr_pkg::lssr_result_t        res_reg;
    lssr_pkg::lssr_result_t        res_next;

    logic advance;

    // the buffered beat moves on when the result slot is free or draining
    assign advance  = in_vld_reg && (!res_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    lssr_step u_step (
        .cur            (state_reg),
        .cmd            (in_cmd_reg),
        .sample         (in_sample_reg),
        .exposure_count (exposure_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            res_vld_reg  <= 1'b0;
            state_reg    <= '0;
            exposure_reg <= lssr_pkg::EXPOSURE_RESET;
        end else begin
            if (cfg_wr_en) begin
                exposure_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg   <= state_next;
                res_vld_reg <= 1'b1;
            end else if (m_tready) begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg    <= s_tuser;
            in_sample_reg <= s_tdata[lssr_pkg::SAMPLE_W-1:0];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_vld_reg;
    assign m_tdata  = {6'd0, res_reg.frame_number, res_reg.pixel_value,
                       res_reg.pixel_index, res_reg.clk_level, res_reg.si_level};
    assign m_tuser  = {res_reg.frame_done, res_reg.pixel_valid};

`ifndef ASSERT_OFF
    // a beat never carries a pixel and a frame mark together
    a_pix_frame_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("pixel and frame_done in the same beat");

    // pixels and frame marks only come on a falling clock edge, SI low
    a_edge_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> (m_tdata[1:0] == 2'b00))
        else $error("capture reported without falling clock edge");

    // pixel position never goes beyond one past the frame-done slot
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pixel_position <=
            lssr_pkg::PIX_POS_W'(lssr_pkg::PIXELS_PER_LINE + 1))
        else $error("pixel position out of range");

    // a buffered beat that cannot move on stays buffered
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |=> in_vld_reg)
        else $error("buffered input beat lost");
`endif

endmodule

>>> tb/lssr_readout_sb.sv
// Scoreboard for the line-scan sensor readout: tracks the SI/clock sequencer
// and holds the pin/pixel/frame beats it expects. Depends on lssr_pkg.
package lssr_readout_sb_pkg;

    import lssr_pkg::*;

    class readout_scoreboard;

        int unsigned       fail_count;
        lssr_result_t      line_beats[$];

        // Sequencer copy
        logic [TICK_W-1:0]  exposure;
        logic [TICK_W-1:0]  tick;
        logic               clk_high;
        logic               si_high;
        int unsigned        pix_pos;
        logic [FRAME_W-1:0] frames;

        function new();
            fail_count = 0;
            exposure   = EXPOSURE_RESET;
            tick       = '0;
            clk_high   = 1'b0;
            si_high    = 1'b0;
            pix_pos    = 0;
            frames     = '0;
        endfunction

        function void set_exposure(logic [TICK_W-1:0] value);
            exposure = value;
        endfunction

        function int unsigned pending();
            return line_beats.size();
        endfunction

        // Advance the sequencer by one accepted input beat and queue its result.
        function void note_input(logic cmd, logic [SAMPLE_W-1:0] sample);
            lssr_result_t r;
            int unsigned  scaled;
            logic [TICK_W:0] next_tick;
            r = '0;
            if (cmd == CMD_RESTART) begin
                tick     = '0;
                clk_high = 1'b0;
                si_high  = 1'b0;
                pix_pos  = 0;
                frames   = '0;
            end else if (tick == '0) begin
                si_high  = 1'b1;
                clk_high = 1'b1;
                tick     = TICK_W'(1);
            end else begin
                if (clk_high) begin
                    // falling edge: SI drops, pixel or frame-done
                    si_high = 1'b0;
                    if (pix_pos < PIXELS_PER_LINE) begin
                        scaled = (int'(sample) * 255) / 4000;
                        r.pixel_valid = 1'b1;
                        r.pixel_index = pix_pos[PIXIDX_W-1:0];
                        r.pixel_value = (scaled > 255) ? 8'd255 : scaled[PIXVAL_W-1:0];
                        pix_pos++;
                    end else if (pix_pos == PIXELS_PER_LINE) begin
                        r.frame_done   = 1'b1;
                        r.frame_number = frames;
                        frames++;
                        pix_pos++;
                    end
                    clk_high = 1'b0;
                end else begin
                    clk_high = 1'b1;
                end
                // wrap test with one extra bit so 65535 is reachable
                next_tick = {1'b0, tick} + 1'b1;
                if (next_tick > {1'b0, exposure}) begin
                    tick    = '0;
                    pix_pos = 0;
                end else begin
                    tick = next_tick[TICK_W-1:0];
                end
            end
            r.si_level  = si_high;
            r.clk_level = clk_high;
            line_beats.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v) begin
                fail_count++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            lssr_result_t exp_r;
            if (line_beats.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none, got tdata=%h tuser=%b",
                         $time, tdata, tuser);
                return;
            end
            exp_r = line_beats.pop_front();
            compare_field("si_level",     32'(exp_r.si_level),     32'(tdata[0]));
            compare_field("clk_level",    32'(exp_r.clk_level),    32'(tdata[1]));
            compare_field("pixel_index",  32'(exp_r.pixel_index),  32'(tdata[9:2]));
            compare_field("pixel_value",  32'(exp_r.pixel_value),  32'(tdata[17:10]));
            compare_field("frame_number", 32'(exp_r.frame_number), 32'(tdata[33:18]));
            compare_field("pixel_valid",  32'(exp_r.pixel_valid),  32'(tuser[0]));
            compare_field("frame_done",   32'(exp_r.frame_done),   32'(tuser[1]));
        endfunction

    endclass

endpackage

>>> tb/tb.sv
// Regression bench for line_scan_sensor_readout: random-gap stream driver,
// random-stall result sink, scoreboard checks. Depends on lssr_pkg, lssr_readout_sb_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lssr_pkg::*;
    import lssr_readout_sb_pkg::*;

    // The run limit covers ~1.4k beats, each with the worst gap and stall,
    // plus idle waits, several times over.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned MAX_WAIT    = 12;

    // Samples placed on falling-edge ticks in the directed part
    localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [8] =
        '{12'd0, 12'd1, 12'd15, 12'd2048, 12'd3999, 12'd4000, 12'd4001, 12'd4095};

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TICK_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = CMD_TICK;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int unsigned cycles         = 0;
    int unsigned send_max_gap   = MAX_WAIT;
    int unsigned recv_max_stall = MAX_WAIT;

    readout_scoreboard sb = new();

    line_scan_sensor_readout i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit; a hang anywhere ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("line_scan_sensor_readout regression: fail");
            $finish;
        end
    end

    // Beat monitor: values sampled at the edge are the pre-edge ones.
    // Input is noted before the result check; a result never shares an edge
    // with its own input beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser, s_tdata[SAMPLE_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
        end
    end

    // Result sink: per beat, hold tready low for a random stall, then take one beat.
    initial begin
        int unsigned stall;
        forever begin
            stall = (recv_max_stall != 0) ? $urandom_range(recv_max_stall, 0) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One input beat after a random gap; returns at the accepting edge with
    // tvalid still high so a back-to-back beat needs no extra assignment.
    task automatic send_beat(input logic cmd, input logic [SAMPLE_W-1:0] sample);
        int unsigned gap;
        gap = (send_max_gap != 0) ? $urandom_range(send_max_gap, 0) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, sample};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait until every queued result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_exposure(input logic [TICK_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_exposure(value);
    endtask

    // Mostly ticks with random content, rare restarts, a share of bright
    // samples; calm stretches with no gaps or stalls now and then.
    task automatic run_random(input int unsigned beats);
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
        bit                  calm;
        calm = 1'b0;
        for (int unsigned i = 0; i < beats; i++) begin
            if (i % 64 == 0) begin
                calm           = ($urandom_range(3, 0) == 0);
                send_max_gap   = calm ? 0 : MAX_WAIT;
                recv_max_stall = calm ? 0 : MAX_WAIT;
            end
            cmd    = ($urandom_range(299, 0) == 0) ? CMD_RESTART : CMD_TICK;
            sample = ($urandom_range(7, 0) == 0) ? SAMPLE_W'($urandom_range(4095, 3990))
                                                 : SAMPLE_W'($urandom_range(4095, 0));
            send_beat(cmd, sample);
        end
        send_max_gap   = MAX_WAIT;
        recv_max_stall = MAX_WAIT;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset exposure of 501: restart, period start, then each
        // corner sample on a falling-edge tick (rising ticks carry full scale,
        // which must be ignored).
        send_beat(CMD_RESTART, 12'd4095);
        send_beat(CMD_TICK, 12'd4095);
        foreach (CORNER_SAMPLES[k]) begin
            send_beat(CMD_TICK, CORNER_SAMPLES[k]);
            send_beat(CMD_TICK, 12'd4095);
        end
        // restart mid-line, twice in a row, then a fresh period start
        send_beat(CMD_RESTART, 12'd0);
        send_beat(CMD_RESTART, 12'd2730);
        send_beat(CMD_TICK, 12'd1365);
        send_beat(CMD_TICK, 12'd4000);

        // Short periods: count 1 wraps every other edge; neither reaches frame done
        write_exposure(16'd1);
        run_random(150);
        write_exposure(16'd2);
        run_random(100);

        // Smallest periods that still reach frame done; extra falling edges
        // after it must stay quiet until the wrap
        write_exposure(16'd259);
        run_random(400);
        write_exposure(16'd260);
        run_random(300);
        write_exposure(16'($urandom_range(520, 261)));
        run_random(280);

        // Widest count: the tick counter keeps counting, no wrap in reach
        write_exposure(16'hFFFF);
        run_random(100);

        // Zero count: a period is only the start tick and one edge tick
        write_exposure(16'd0);
        run_random(50);

        wait_idle();
        if (sb.fail_count == 0) begin
            $display("line_scan_sensor_readout regression: pass");
        end else begin
            $display("line_scan_sensor_readout regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/lssr_pkg.sv
hdl/lssr_scale.sv
hdl/lssr_step.sv
hdl/line_scan_sensor_readout.sv
tb/lssr_readout_sb.sv
tb/tb.sv
